/* rtl/jbt_pkg.sv */
// types and constants shared by the json byte tokenizer
package jbt_pkg;

    localparam int MAX_RES   = 3;
    localparam int RES_DEPTH = 6;
    localparam int CNT_W     = $clog2(RES_DEPTH + 1);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;

    typedef enum logic [1:0] {
        MODE_BETWEEN = 2'd0,
        MODE_STRING  = 2'd1,
        MODE_ESCAPE  = 2'd2,
        MODE_BARE    = 2'd3
    } t_scan_mode;

    typedef enum logic [3:0] {
        KIND_LBRACE       = 4'd0,
        KIND_RBRACE       = 4'd1,
        KIND_LBRACKET     = 4'd2,
        KIND_RBRACKET     = 4'd3,
        KIND_COLON        = 4'd4,
        KIND_COMMA        = 4'd5,
        KIND_VALUE        = 4'd6,
        KIND_END          = 4'd7,
        KIND_UNTERMINATED = 4'd8
    } t_kind;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic [3:0] token_kind;
        logic [7:0] value_char;
        logic       char_valid;
        logic       token_last;
    } t_out;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_CR) || (c == CH_LF) || (c == CH_TAB);
    endfunction

    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_value_letter(input logic [7:0] c);
        return (c == "-") || (c == "+") || (c == ".") ||
               ((c >= "0") && (c <= "9")) ||
               (c == "f") || (c == "a") || (c == "l") || (c == "s") ||
               (c == "e") || (c == "t") || (c == "r") || (c == "u");
    endfunction

    // structural character to its token kind, valid flag in the top bit
    function automatic logic [4:0] struct_kind(input logic [7:0] c);
        case (c)
            CH_LBRACE: return {1'b1, KIND_LBRACE};
            CH_RBRACE: return {1'b1, KIND_RBRACE};
            CH_LBRACK: return {1'b1, KIND_LBRACKET};
            CH_RBRACK: return {1'b1, KIND_RBRACKET};
            CH_COLON:  return {1'b1, KIND_COLON};
            CH_COMMA:  return {1'b1, KIND_COMMA};
            default:   return {1'b0, KIND_VALUE};
        endcase
    endfunction

    function automatic t_out mk_res(input t_kind k, input logic [7:0] ch,
                                    input logic v, input logic last);
        t_out r;
        r.token_kind = k;
        r.value_char = v ? ch : 8'd0;
        r.char_valid = v;
        r.token_last = last;
        return r;
    endfunction

endpackage

/* rtl/json_byte_tokenizer.sv */
// json byte tokenizer top level: byte scanner and result queue
//
// Usage: one byte of JSON text per input request on the in channel
// (byte_in, end_of_input set on the final byte of a text). Token results
// leave one per output request on the out channel: kind, an optional value
// character and a last flag closing each token.
// Blanks between tokens give no result; one byte gives up to three results.
// The results of a byte enter the result queue in the cycle after it is accepted.
// Throughput: while out ready stays high, one byte per cycle as long as each
// byte gives at most one result, and one result per cycle out of the
// six-entry result queue; a byte is taken when it has room for three more.
// A bare value's last character is held until the byte after it arrives.
// Reset: the scanner returns to between tokens, the hold and the queue are
// emptied. After the final byte of a text the scanner resets itself too.
// A stalled receiver keeps the head result steady; bytes keep being taken
// until the queue cannot hold a worst-case burst, then in ready drops.
module json_byte_tokenizer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  jbt_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output jbt_pkg::t_out o_out_data
);
    import jbt_pkg::*;

    t_scan_mode r_mode, n_mode;
    logic [7:0] r_held, n_held;
    logic       r_held_v, n_held_v;

    t_out             r_slot [RES_DEPTH];
    t_out             n_slot [RES_DEPTH];
    logic [CNT_W-1:0] r_count, n_count;

    t_out       res [MAX_RES];
    logic [1:0] res_n;

    logic             acc, pop;
    logic [CNT_W-1:0] wpos;
    logic [7:0]       c, lc;
    logic             fin;
    logic [4:0]       sk;

    assign c   = i_in_data.byte_in;
    assign fin = i_in_data.end_of_input;
    assign lc  = fold_lower(c);
    assign sk  = struct_kind(c);

    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_slot[0];
    assign pop         = o_out_valid && i_out_ready;
    assign o_in_ready  = (r_count <= CNT_W'(RES_DEPTH - MAX_RES)) ||
                         ((r_count == CNT_W'(RES_DEPTH - MAX_RES + 1)) && pop);
    assign acc         = i_in_valid && o_in_ready;
    assign wpos        = r_count - CNT_W'(pop);

    // next scanner state
    always_comb begin
        n_mode   = r_mode;
        n_held   = r_held;
        n_held_v = r_held_v;
        if (acc) begin
            case (r_mode)
                MODE_STRING: begin
                    if (c == CH_QUOTE) begin
                        n_held_v = 1'b0;
                        n_mode   = MODE_BETWEEN;
                    end else begin
                        n_held   = c;
                        n_held_v = 1'b1;
                        if (c == CH_BSLASH) n_mode = MODE_ESCAPE;
                    end
                end
                MODE_ESCAPE: begin
                    n_held   = c;
                    n_held_v = 1'b1;
                    n_mode   = MODE_STRING;
                end
                default: begin
                    // bare value: a non-letter ends it and is rescanned
                    if ((r_mode == MODE_BARE) && is_value_letter(lc)) begin
                        n_held   = lc;
                        n_held_v = 1'b1;
                    end else begin
                        n_held_v = 1'b0;
                        n_mode   = MODE_BETWEEN;
                        if (is_blank(c) || sk[4]) begin
                            n_mode = MODE_BETWEEN;
                        end else if (c == CH_QUOTE) begin
                            n_mode = MODE_STRING;
                        end else if (is_value_letter(lc)) begin
                            n_held   = lc;
                            n_held_v = 1'b1;
                            n_mode   = MODE_BARE;
                        end
                    end
                end
            endcase
            if (fin) begin
                n_mode   = MODE_BETWEEN;
                n_held   = 8'd0;
                n_held_v = 1'b0;
            end
        end
    end

    // results of the accepted byte
    always_comb begin
        logic after_bare;
        after_bare = 1'b0;
        res_n      = 2'd0;
        for (int k = 0; k < MAX_RES; k++) res[k] = mk_res(KIND_END, 8'd0, 1'b0, 1'b1);
        case (r_mode)
            MODE_STRING: begin
                if (c == CH_QUOTE) begin
                    res[res_n] = mk_res(KIND_VALUE, r_held, r_held_v, 1'b1);
                    res_n      = res_n + 2'd1;
                end else if (r_held_v) begin
                    res[res_n] = mk_res(KIND_VALUE, r_held, 1'b1, 1'b0);
                    res_n      = res_n + 2'd1;
                end
            end
            MODE_ESCAPE: begin
                if (r_held_v) begin
                    res[res_n] = mk_res(KIND_VALUE, r_held, 1'b1, 1'b0);
                    res_n      = res_n + 2'd1;
                end
            end
            default: begin
                if ((r_mode == MODE_BARE) && is_value_letter(lc)) begin
                    after_bare = 1'b1;
                    if (r_held_v) begin
                        res[res_n] = mk_res(KIND_VALUE, r_held, 1'b1, 1'b0);
                        res_n      = res_n + 2'd1;
                    end
                end else begin
                    if (r_mode == MODE_BARE) begin
                        res[res_n] = mk_res(KIND_VALUE, r_held, 1'b1, 1'b1);
                        res_n      = res_n + 2'd1;
                    end
                    if (is_blank(c) || (c == CH_QUOTE)) begin
                        res_n = res_n;
                    end else if (sk[4]) begin
                        res[res_n] = mk_res(t_kind'(sk[3:0]), 8'd0, 1'b0, 1'b1);
                        res_n      = res_n + 2'd1;
                    end else if (is_value_letter(lc)) begin
                        after_bare = 1'b1;
                    end else begin
                        res[res_n] = mk_res(KIND_VALUE, 8'd0, 1'b0, 1'b1);
                        res_n      = res_n + 2'd1;
                    end
                end
            end
        endcase
        if (fin) begin
            // close whatever the last byte left open, then the end token
            if (after_bare) begin
                res[res_n] = mk_res(KIND_VALUE, (r_mode == MODE_BARE) ? lc : lc,
                                    1'b1, 1'b1);
                res_n      = res_n + 2'd1;
            end else if (((r_mode == MODE_STRING) && (c != CH_QUOTE)) ||
                         (r_mode == MODE_ESCAPE) ||
                         ((r_mode == MODE_BETWEEN) && (c == CH_QUOTE)) ||
                         ((r_mode == MODE_BARE) && (c == CH_QUOTE))) begin
                res[res_n] = mk_res(KIND_UNTERMINATED, 8'd0, 1'b0, 1'b1);
                res_n      = res_n + 2'd1;
            end
            res[res_n] = mk_res(KIND_END, 8'd0, 1'b0, 1'b1);
            res_n      = res_n + 2'd1;
        end
    end

    // result queue: head at slot 0, shifts on each output request
    always_comb begin
        logic [CNT_W-1:0] rel;
        rel = '0;
        for (int i = 0; i < RES_DEPTH; i++) begin
            if (pop && (i < RES_DEPTH - 1)) n_slot[i] = r_slot[(i + 1) % RES_DEPTH];
            else n_slot[i] = r_slot[i];
            rel = CNT_W'(i) - wpos;
            if (acc && (CNT_W'(i) >= wpos) && (rel < CNT_W'(res_n))) begin
                n_slot[i] = res[rel[1:0]];
            end
        end
        n_count = wpos + (acc ? CNT_W'(res_n) : CNT_W'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_BETWEEN;
            r_held   <= 8'd0;
            r_held_v <= 1'b0;
            r_count  <= '0;
        end else begin
            r_mode   <= n_mode;
            r_held   <= n_held;
            r_held_v <= n_held_v;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < RES_DEPTH; i++) r_slot[i] <= n_slot[i];
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(RES_DEPTH))
        else $error("result queue overflow");

    a_fin_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && fin) |=> (r_mode == MODE_BETWEEN) && !r_held_v)
        else $error("scanner not reset after final byte");

    a_bare_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_BARE) |-> r_held_v)
        else $error("bare value without held character");

    a_fin_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && fin) |-> (res_n != 2'd0) && (res[res_n - 2'd1].token_kind == KIND_END))
        else $error("final byte without end token");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.token_kind <= KIND_UNTERMINATED))
        else $error("bad token kind");

endmodule

/* sim/tb_json_byte_tokenizer.sv */
// testbench for the json byte tokenizer: directed and random bytes checked by a token predictor
module tb_json_byte_tokenizer;
    timeunit 1ns;
    timeprecision 1ps;

    import jbt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 220;
    localparam string BARE_SET = "-+.0123456789aelrstuAELRSTUfF";
    localparam string BLANK_SET = " \t\r\n";

    class token_scoreboard;
        t_out pending_tokens[$];
        t_scan_mode mode;
        logic [7:0] held;
        logic held_ok;
        int n_bytes, n_texts, n_checked, n_errors;

        function new();
            clear();
        endfunction

        function void clear();
            mode = MODE_BETWEEN;
            held = 8'd0;
            held_ok = 1'b0;
        endfunction

        function void push_token(t_kind k, logic [7:0] ch, logic v, logic last);
            t_out r;
            r.token_kind = k;
            r.value_char = v ? ch : 8'd0;
            r.char_valid = v;
            r.token_last = last;
            pending_tokens.push_back(r);
        endfunction

        function logic [7:0] lower(logic [7:0] c);
            return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        endfunction

        function logic bare_char(logic [7:0] c);
            return c == "-" || c == "+" || c == "." || (c >= "0" && c <= "9") ||
                   c == "a" || c == "e" || c == "f" || c == "l" ||
                   c == "r" || c == "s" || c == "t" || c == "u";
        endfunction

        // previous held character goes out, the new one waits for its successor
        function void hold_char(logic [7:0] c);
            if (held_ok)
                push_token(KIND_VALUE, held, 1'b1, 1'b0);
            held = c;
            held_ok = 1'b1;
        endfunction

        function void scan_idle(logic [7:0] c);
            logic [7:0] lc;
            lc = lower(c);
            if (c == CH_SPACE || c == CH_CR || c == CH_LF || c == CH_TAB)
                return;
            case (c)
                CH_LBRACE: push_token(KIND_LBRACE, 8'd0, 1'b0, 1'b1);
                CH_RBRACE: push_token(KIND_RBRACE, 8'd0, 1'b0, 1'b1);
                CH_LBRACK: push_token(KIND_LBRACKET, 8'd0, 1'b0, 1'b1);
                CH_RBRACK: push_token(KIND_RBRACKET, 8'd0, 1'b0, 1'b1);
                CH_COLON:  push_token(KIND_COLON, 8'd0, 1'b0, 1'b1);
                CH_COMMA:  push_token(KIND_COMMA, 8'd0, 1'b0, 1'b1);
                CH_QUOTE: begin
                    mode = MODE_STRING;
                    held_ok = 1'b0;
                end
                default: begin
                    if (bare_char(lc)) begin
                        held = lc;
                        held_ok = 1'b1;
                        mode = MODE_BARE;
                    end else begin
                        // stray byte gives an empty value
                        push_token(KIND_VALUE, 8'd0, 1'b0, 1'b1);
                    end
                end
            endcase
        endfunction

        function void add_byte(t_in req);
            logic [7:0] c, lc;
            c = req.byte_in;
            lc = lower(c);
            n_bytes++;
            case (mode)
                MODE_STRING: begin
                    if (c == CH_QUOTE) begin
                        push_token(KIND_VALUE, held, held_ok, 1'b1);
                        held_ok = 1'b0;
                        mode = MODE_BETWEEN;
                    end else begin
                        hold_char(c);
                        if (c == CH_BSLASH)
                            mode = MODE_ESCAPE;
                    end
                end
                MODE_ESCAPE: begin
                    hold_char(c);
                    mode = MODE_STRING;
                end
                MODE_BARE: begin
                    if (bare_char(lc)) begin
                        hold_char(lc);
                    end else begin
                        push_token(KIND_VALUE, held, 1'b1, 1'b1);
                        held_ok = 1'b0;
                        mode = MODE_BETWEEN;
                        scan_idle(c);
                    end
                end
                default: scan_idle(c);
            endcase
            if (req.end_of_input) begin
                if (mode == MODE_BARE)
                    push_token(KIND_VALUE, held, 1'b1, 1'b1);
                else if (mode == MODE_STRING || mode == MODE_ESCAPE)
                    push_token(KIND_UNTERMINATED, 8'd0, 1'b0, 1'b1);
                push_token(KIND_END, 8'd0, 1'b0, 1'b1);
                clear();
                n_texts++;
            end
        endfunction

        function void check_token(t_out got);
            t_out want;
            if (pending_tokens.size() == 0) begin
                $display("%0t: unexpected token, actual kind %0d char %h valid %b last %b",
                         $time, got.token_kind, got.value_char, got.char_valid,
                         got.token_last);
                n_errors++;
                return;
            end
            want = pending_tokens.pop_front();
            n_checked++;
            if (got.token_kind !== want.token_kind || got.value_char !== want.value_char ||
                got.char_valid !== want.char_valid || got.token_last !== want.token_last) begin
                $display("%0t: token mismatch, expected kind %0d char %h valid %b last %b",
                         $time, want.token_kind, want.value_char, want.char_valid,
                         want.token_last);
                $display("%0t:                 actual   kind %0d char %h valid %b last %b",
                         $time, got.token_kind, got.value_char, got.char_valid,
                         got.token_last);
                n_errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    token_scoreboard board = new();
    int send_idle = 34;
    int recv_idle = 86;
    int cycles = 0;

    json_byte_tokenizer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d tokens still pending",
                     cycles, board.pending_tokens.size());
            $display("simulation failed");
            $finish;
        end
    end

    // token receiver with random stalls
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_token(o_out_data);
        i_out_ready <= ($urandom_range(99) >= recv_idle);
    end

    function automatic logic end_flag();
        return $urandom_range(39) == 0;
    endfunction

    // one request on the byte channel, with a random gap in front of it
    task automatic send_byte(input logic [7:0] b, input logic fin);
        t_in req;
        int gap;
        req.byte_in = b;
        req.end_of_input = fin;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        do @(posedge i_clk); while (!o_in_ready);
        board.add_byte(req);
    endtask

    task automatic send_text(input string s, input logic fin);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], fin && i == s.len() - 1);
    endtask

    task automatic send_token();
        int pick, len;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 20) begin
            case ($urandom_range(5))
                0: b = CH_LBRACE;
                1: b = CH_RBRACE;
                2: b = CH_LBRACK;
                3: b = CH_RBRACK;
                4: b = CH_COLON;
                default: b = CH_COMMA;
            endcase
            send_byte(b, end_flag());
        end else if (pick < 35) begin
            len = $urandom_range(1, 3);
            repeat (len) send_byte(BLANK_SET[$urandom_range(3)], end_flag());
        end else if (pick < 65) begin
            send_byte(CH_QUOTE, end_flag());
            len = $urandom_range(0, 6);
            repeat (len) begin
                if ($urandom_range(5) == 0) begin
                    send_byte(CH_BSLASH, end_flag());
                    send_byte(8'($urandom_range(255)), end_flag());
                end else begin
                    b = 8'($urandom_range(255));
                    while (b == CH_QUOTE)
                        b = 8'($urandom_range(255));
                    send_byte(b, end_flag());
                end
            end
            if ($urandom_range(9) != 0)
                send_byte(CH_QUOTE, end_flag());
        end else if (pick < 88) begin
            len = $urandom_range(1, 5);
            repeat (len) send_byte(BARE_SET[$urandom_range(BARE_SET.len() - 1)], end_flag());
        end else begin
            send_byte(8'($urandom_range(255)), end_flag());
        end
    endtask

    task automatic run_random(input int count);
        int target;
        target = board.n_bytes + count;
        while (board.n_bytes < target)
            send_token();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // escaped quote, mixed case literal, signed number, empty string, stray byte
        send_text("{\"\\\"\":[tRuE,-.5],\"\":#}", 1'b1);
        // text ending inside a bare value
        send_text("\t7", 1'b1);
        // text ending on an opening quote, then right after a backslash
        send_text("\"", 1'b1);
        send_text("\"\\", 1'b1);

        run_random(RANDOM_ITEMS / 3);
        send_idle = 86;
        recv_idle = 34;
        run_random(RANDOM_ITEMS / 3);
        send_idle = 0;
        recv_idle = 0;
        run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        // flush any open token
        send_byte(CH_SPACE, 1'b1);
        i_in_valid <= 1'b0;

        while (board.pending_tokens.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("sent %0d bytes across %0d texts under three stall patterns",
                 board.n_bytes, board.n_texts);
        $display("checked %0d token results, %0d errors", board.n_checked, board.n_errors);
        if (board.n_errors == 0 && board.pending_tokens.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/jbt_pkg.sv
rtl/json_byte_tokenizer.sv
sim/tb_json_byte_tokenizer.sv
